[sv/utf8_to_ucs2_decode_macros.svh]
// Assertion macros shared by the UTF-8 to UCS-2 decoder modules.
`ifndef UTF8_TO_UCS2_DECODE_MACROS_SVH
`define UTF8_TO_UCS2_DECODE_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked at every rising clock edge outside reset.
`define UTF8D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define UTF8D_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define UTF8D_ASSERT(lbl, prop, msg)

`define UTF8D_NEVER(lbl, expr, msg)

`endif

`endif

[sv/utf8dec_pkg.sv]
// Types and constants shared by the UTF-8 to UCS-2 decoder modules.
package utf8dec_pkg;

  localparam logic [1:0] ST_CHAR = 2'd0;
  localparam logic [1:0] ST_END  = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [7:0] LIM_ASCII = 8'h7F;
  localparam logic [7:0] LIM_LEAD2 = 8'hDF;
  localparam logic [7:0] LIM_LEAD3 = 8'hEF;

  typedef enum logic [2:0] {
    OP_END,
    OP_CHAR,
    OP_ERR,
    OP_LEAD2,
    OP_LEAD3,
    OP_MID,
    OP_LAST
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } op_entry_t;

endpackage

[sv/utf8dec_front.sv]
// Front end: tracks sequence position and classifies each input byte into an op.
`include "utf8_to_ucs2_decode_macros.svh"

module utf8dec_front
  import utf8dec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       q_full_i,
  output logic       push_o,
  output op_entry_t  push_entry_o
);

  logic [1:0] pending_q, pending_d;
  op_e        op;

  assign push_o = in_valid_i && !q_full_i;

  always_comb begin
    pending_d = pending_q;
    op        = OP_ERR;
    if (pending_q == 2'd0) begin
      if (in_byte_i == 8'h00) begin
        op = OP_END;
      end else if (in_byte_i <= LIM_ASCII) begin
        op = OP_CHAR;
      end else if (in_byte_i <= LIM_LEAD2) begin
        op        = OP_LEAD2;
        pending_d = 2'd1;
      end else if (in_byte_i <= LIM_LEAD3) begin
        op        = OP_LEAD3;
        pending_d = 2'd2;
      end else begin
        op = OP_ERR;
      end
    end else if (!in_byte_i[7]) begin
      op        = OP_ERR;
      pending_d = 2'd0;
    end else if (pending_q >= 2'd2) begin
      op        = OP_MID;
      pending_d = 2'd1;
    end else begin
      op        = OP_LAST;
      pending_d = 2'd0;
    end
  end

  assign push_entry_o.op   = op;
  assign push_entry_o.data = in_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
    end else if (push_o) begin
      pending_q <= pending_d;
    end
  end

  `UTF8D_NEVER(a_pending_range, pending_q == 2'd3, "pending count reached 3")
  `UTF8D_ASSERT(a_lead_from_idle,
                push_o && (op == OP_LEAD2 || op == OP_LEAD3) |-> pending_q == 2'd0,
                "lead op issued mid-sequence")

endmodule

[sv/utf8dec_fifo.sv]
// Small op queue between the classifier and the character builder.
`include "utf8_to_ucs2_decode_macros.svh"

module utf8dec_fifo
  import utf8dec_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  op_entry_t push_entry_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output op_entry_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  op_entry_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      priority if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end else begin
        count_q <= count_q;
      end
    end
  end

  `UTF8D_NEVER(a_no_overflow, push_i && full_o, "push into full queue")
  `UTF8D_NEVER(a_no_underflow, pop_i && empty_o, "pop from empty queue")

endmodule

[sv/utf8dec_back.sv]
// Back end: builds characters from queued ops and holds the output register.
`include "utf8_to_ucs2_decode_macros.svh"

module utf8dec_back
  import utf8dec_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  op_entry_t   head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] char_value_o,
  output logic [1:0]  status_o
);

  logic [15:0] accum_q, accum_d;
  logic        out_valid_q;
  logic [15:0] char_q, char_d;
  logic [1:0]  status_q, status_d;
  logic        emits;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    accum_d  = accum_q;
    emits    = 1'b0;
    char_d   = 16'h0000;
    status_d = ST_CHAR;
    unique case (head_i.op)
      OP_END: begin
        emits    = 1'b1;
        status_d = ST_END;
      end
      OP_CHAR: begin
        emits  = 1'b1;
        char_d = {8'h00, head_i.data};
      end
      OP_ERR: begin
        emits    = 1'b1;
        status_d = ST_ERR;
        accum_d  = 16'h0000;
      end
      OP_LEAD2: begin
        accum_d = {5'b0, head_i.data[4:0], 6'b0};
      end
      OP_LEAD3: begin
        accum_d = {head_i.data[3:0], 12'h000};
      end
      OP_MID: begin
        accum_d = accum_q | {4'b0, head_i.data[5:0], 6'b0};
      end
      OP_LAST: begin
        emits   = 1'b1;
        char_d  = accum_q | {10'b0, head_i.data[5:0]};
        accum_d = 16'h0000;
      end
      default: begin
        accum_d = accum_q;
      end
    endcase
  end

  assign pop_o = !empty_i && (!emits || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q     <= 16'h0000;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        accum_q <= accum_d;
      end
      if (pop_o && emits) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emits) begin
      char_q   <= char_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign char_value_o = char_q;
  assign status_o     = status_q;

  `UTF8D_NEVER(a_no_overwrite, pop_o && emits && out_valid_q && out_stall_i,
               "held result overwritten")
  `UTF8D_ASSERT(a_zero_on_nonchar, out_valid_q && status_q != ST_CHAR |-> char_q == 16'h0000,
                "end or error beat carries a character")

endmodule

[sv/utf8_to_ucs2_decode.sv]
// Top level of the UTF-8 to UCS-2 stream decoder.
//
// Input channel: one UTF-8 byte per beat on in_byte_i, in_valid_i / in_stall_o.
// Output channel: char_value_o and status_o per beat, out_valid_o / out_stall_i.
// status: 0 character, 1 end of string (zero byte at idle), 2 malformed sequence.
// Lead and middle bytes of a multi-byte sequence produce no output beat.
// Throughput: one byte per cycle, sustained, while the output is not stalled.
// A byte that completes a result passes through the op queue and then the output
// register before the result is offered, when the op queue is empty.
// The classifier writes each byte into a FifoDepth-entry op queue; the builder
// drains one op per cycle; emitting ops wait for the single output register.
// While the output is stalled, ops that emit nothing keep draining; the queue
// fills and in_stall_o rises once FifoDepth ops wait.
// Reset clears the sequence state, the queue and the output valid; the block
// takes bytes in the first cycle after reset.
`include "utf8_to_ucs2_decode_macros.svh"

module utf8_to_ucs2_decode
  import utf8dec_pkg::*;
#(
  parameter int unsigned FifoDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] char_value_o,
  output logic [1:0]  status_o
);

  logic      q_full, q_empty, push, pop;
  op_entry_t push_entry, head;

  assign in_stall_o = q_full;

  utf8dec_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_byte_i    (in_byte_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  utf8dec_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .empty_o      (q_empty),
    .head_o       (head)
  );

  utf8dec_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .char_value_o (char_value_o),
    .status_o     (status_o)
  );

endmodule

[sim/utf8_to_ucs2_decode_tb.sv]
// Self-checking testbench for the UTF-8 to UCS-2 decoder: directed table, then random traffic.
`timescale 1ns / 1ps

module utf8_to_ucs2_decode_tb;
  import utf8dec_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned PhaseBytes   = 450;
  localparam int unsigned PressureHold = 250;
  localparam int unsigned DirCount     = 25;

  typedef struct packed {
    logic [15:0] ch;
    logic [1:0]  st;
  } char_beat_t;

  typedef struct packed {
    logic [7:0] b;
    logic       fixed;
    char_beat_t res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  in_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] char_value_o;
  logic [1:0]  status_o;

  logic [1:0]  dec_pending;
  logic [15:0] dec_accum;
  char_beat_t  expected_chars[$];

  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned cycle_count;
  int unsigned phase;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned hold_cycles;
  bit          pressure_done;

  dir_row_t    directed [DirCount];

  utf8_to_ucs2_decode i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .char_value_o (char_value_o),
    .status_o     (status_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit decode_byte(input logic [7:0] b, output char_beat_t res);
    res = '0;
    if (dec_pending == 2'd0) begin
      if (b == 8'h00) begin
        res.st = ST_END;
        return 1'b1;
      end
      if (b <= LIM_ASCII) begin
        res.ch = {8'h00, b};
        res.st = ST_CHAR;
        return 1'b1;
      end
      if (b <= LIM_LEAD2) begin
        dec_accum   = {5'd0, b[4:0], 6'd0};
        dec_pending = 2'd1;
        return 1'b0;
      end
      if (b <= LIM_LEAD3) begin
        dec_accum   = {b[3:0], 12'd0};
        dec_pending = 2'd2;
        return 1'b0;
      end
      dec_accum = '0;
      res.st    = ST_ERR;
      return 1'b1;
    end
    if (!b[7]) begin
      dec_pending = 2'd0;
      dec_accum   = '0;
      res.st      = ST_ERR;
      return 1'b1;
    end
    if (dec_pending >= 2'd2) begin
      dec_accum   = dec_accum | {4'd0, b[5:0], 6'd0};
      dec_pending = 2'd1;
      return 1'b0;
    end
    res.ch      = dec_accum | {10'd0, b[5:0]};
    res.st      = ST_CHAR;
    dec_pending = 2'd0;
    dec_accum   = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_byte(input logic [7:0] b, input logic fixed, input char_beat_t fixed_res);
    char_beat_t res;
    bit         has_res;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    has_res = decode_byte(b, res);
    if (fixed) expected_chars.push_back(fixed_res);
    else if (has_res) expected_chars.push_back(res);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 127));
  endfunction

  task automatic send_random_sequence();
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 30) begin
      send_byte(8'($urandom_range(1, 127)), 1'b0, '0);
    end else if (kind < 50) begin
      send_byte(8'($urandom_range(8'h80, 8'hDF)), 1'b0, '0);
      send_byte(cont_byte(), 1'b0, '0);
    end else if (kind < 70) begin
      send_byte(8'($urandom_range(8'hE0, 8'hEF)), 1'b0, '0);
      send_byte(cont_byte(), 1'b0, '0);
      send_byte(cont_byte(), 1'b0, '0);
    end else if (kind < 78) begin
      send_byte(8'h00, 1'b0, '0);
    end else if (kind < 85) begin
      send_byte(8'($urandom_range(8'hF0, 8'hFF)), 1'b0, '0);
    end else if (kind < 93) begin
      // broken sequence: bit 7 clear where a continuation belongs, unless a 2-byte char ended
      send_byte(8'($urandom_range(8'h80, 8'hEF)), 1'b0, '0);
      if ($urandom_range(1)) send_byte(cont_byte(), 1'b0, '0);
      send_byte(8'($urandom_range(0, 127)), 1'b0, '0);
    end else begin
      send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    char_beat_t exp_beat;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected beat ch=%h st=%0d", char_value_o, status_o));
      end else begin
        exp_beat = expected_chars.pop_front();
        if (char_value_o !== exp_beat.ch)
          report_mismatch($sformatf("char_value %h, want %h", char_value_o, exp_beat.ch));
        if (status_o !== exp_beat.st)
          report_mismatch($sformatf("status %0d, want %0d", status_o, exp_beat.st));
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back the block up
  initial begin
    forever begin
      @(negedge clk_i);
      if (phase == 2 && !pressure_done) begin
        hold_cycles   = PressureHold;
        pressure_done = 1'b1;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < sink_stall_pct);
      end
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_byte_i      = 8'h00;
    out_stall_i    = 1'b0;
    dec_pending    = 2'd0;
    dec_accum      = '0;
    mismatches     = 0;
    bytes_sent     = 0;
    cycle_count    = 0;
    phase          = 0;
    src_idle_pct   = 18;
    sink_stall_pct = 81;
    hold_cycles    = 0;
    pressure_done  = 1'b0;

    directed = '{
      '{8'h00, 1'b1, '{16'h0000, ST_END}},
      '{8'h01, 1'b1, '{16'h0001, ST_CHAR}},
      '{8'h7F, 1'b1, '{16'h007F, ST_CHAR}},
      '{8'hF0, 1'b1, '{16'h0000, ST_ERR}},
      '{8'hFF, 1'b1, '{16'h0000, ST_ERR}},
      '{8'h80, 1'b0, '0},
      '{8'h80, 1'b0, '0},
      '{8'hDF, 1'b0, '0},
      '{8'hBF, 1'b1, '{16'h07FF, ST_CHAR}},
      '{8'hE0, 1'b0, '0},
      '{8'h80, 1'b0, '0},
      '{8'h80, 1'b0, '0},
      '{8'hEF, 1'b0, '0},
      '{8'hBF, 1'b0, '0},
      '{8'hBF, 1'b1, '{16'hFFFF, ST_CHAR}},
      '{8'hC3, 1'b0, '0},
      '{8'h41, 1'b1, '{16'h0000, ST_ERR}},
      '{8'hE2, 1'b0, '0},
      '{8'h82, 1'b0, '0},
      '{8'h00, 1'b1, '{16'h0000, ST_ERR}},
      '{8'hBF, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'h00, 1'b1, '{16'h0000, ST_END}},
      '{8'hE1, 1'b0, '0},
      '{8'h7F, 1'b1, '{16'h0000, ST_ERR}}
    };

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_byte(directed[i].b, directed[i].fixed, directed[i].res);

    for (int p = 0; p < 3; p++) begin
      phase          = p;
      src_idle_pct   = (p == 0) ? 18 : (p == 1) ? 81 : 0;
      sink_stall_pct = (p == 0) ? 81 : (p == 1) ? 18 : 0;
      for (int unsigned target = bytes_sent + PhaseBytes; bytes_sent < target;)
        send_random_sequence();
    end
    in_valid_i <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (expected_chars.size() != 0)
      report_mismatch($sformatf("%0d beats never arrived", expected_chars.size()));
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
